@@ rtl/hkhd_pkg.sv @@
// Shared constants and types of the Hall key hysteresis detector.
`timescale 1ns / 1ps

package hkhd_pkg;

  localparam int IDX_W     = 4;
  localparam int RAW_W     = 13;
  localparam int MV_W      = 12;
  localparam int THR_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam int SENSORS_DEF  = 16;
  localparam int SAMPLES_DEF  = 8;
  localparam int ADC_BITS_DEF = 12;

  localparam int unsigned MV_FULL = 3300;

  localparam logic [THR_W-1:0] HYST_RST   = 12'd50;
  localparam logic             CAL_EN_RST = 1'b1;
  localparam logic [THR_W-1:0] SWING_RST  = 12'd800;
  localparam logic [THR_W-1:0] DFLT_RST   = 12'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HYSTERESIS = 2'd0,
    CFG_CAL_ENABLE = 2'd1,
    CFG_SWING      = 2'd2,
    CFG_DEFAULT    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } key_event_e;

  typedef struct packed {
    logic [THR_W-1:0] hysteresis_mv;
    logic             calibrate_enable;
    logic [THR_W-1:0] active_swing_mv;
    logic [THR_W-1:0] default_threshold_mv;
  } cfg_t;

  typedef struct packed {
    logic            window_done;
    logic [MV_W-1:0] average_mv;
    logic            key_pressed;
    key_event_e      key_event;
    logic            calibrated_now;
  } bank_res_t;

endpackage

@@ rtl/hkhd_sensor_bank.sv @@
// Per-sensor window accumulation, calibration and hysteresis state.
`timescale 1ns / 1ps

module hkhd_sensor_bank
  import hkhd_pkg::*;
#(
  parameter int SENSORS = SENSORS_DEF,
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [IDX_W-1:0] sensor_i,
  input  logic             err_i,
  input  logic [MV_W-1:0]  mv_i,
  input  cfg_t             cfg_i,
  output bank_res_t        res_o
);

  localparam int SIDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W  = $clog2(MV_FULL * SAMPLES + 1);
  localparam int CLOG_S = $clog2(SAMPLES);
  localparam int SH     = SUM_W + CLOG_S;
  localparam int unsigned RECIP = ((2 ** SH) + SAMPLES - 1) / SAMPLES;
  localparam int AVG_PW = SH + MV_W;

  logic [SUM_W-1:0] sum_q   [SENSORS];
  logic [CNT_W-1:0] cnt_q   [SENSORS];
  logic             press_q [SENSORS];
  logic             calib_q [SENSORS];
  logic [THR_W-1:0] thr_q   [SENSORS];

  logic              idx_ok;
  logic [SIDX_W-1:0] sel;
  logic [SUM_W-1:0]  sum_new;
  logic              done;
  logic [AVG_PW-1:0] avg_prod;
  logic [MV_W-1:0]   avg;
  logic              calib;
  logic [THR_W-1:0]  thr_use;
  logic [THR_W:0]    thr_raw;
  logic [THR_W-1:0]  thr_new;
  logic              do_press;
  logic              do_release;
  logic              press_next;

  assign idx_ok   = ({1'b0, sensor_i} < (IDX_W + 1)'(SENSORS));
  assign sel      = idx_ok ? sensor_i[SIDX_W-1:0] : '0;
  assign sum_new  = sum_q[sel] + SUM_W'(mv_i);
  assign done     = idx_ok && !err_i && (cnt_q[sel] == CNT_W'(SAMPLES - 1));
  assign avg_prod = AVG_PW'(sum_new) * AVG_PW'(RECIP);
  assign avg      = avg_prod[SH +: MV_W];

  assign calib   = done && cfg_i.calibrate_enable && !calib_q[sel] && (avg != '0);
  assign thr_use = calib_q[sel] ? thr_q[sel] : cfg_i.default_threshold_mv;
  assign thr_raw = {1'b0, avg} + {2'b00, cfg_i.active_swing_mv[THR_W-1:1]};
  assign thr_new = thr_raw[THR_W] ? '1 : thr_raw[THR_W-1:0];

  assign do_press   = done && !calib && !press_q[sel] && (avg >= thr_use);
  assign do_release = done && !calib && press_q[sel]
                      && (({1'b0, avg} + {1'b0, cfg_i.hysteresis_mv}) <= {1'b0, thr_use});
  assign press_next = do_press ? 1'b1 : (do_release ? 1'b0 : press_q[sel]);

  always_comb begin
    res_o                = '0;
    res_o.key_event      = EV_NONE;
    res_o.window_done    = done;
    res_o.average_mv     = done ? avg : '0;
    res_o.key_pressed    = idx_ok && press_next;
    res_o.calibrated_now = calib;
    if (do_press) begin
      res_o.key_event = EV_PRESS;
    end else if (do_release) begin
      res_o.key_event = EV_RELEASE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '{default: '0};
      cnt_q   <= '{default: '0};
      press_q <= '{default: 1'b0};
      calib_q <= '{default: 1'b0};
    end else if (fire_i && idx_ok) begin
      if (err_i || done) begin
        sum_q[sel] <= '0;
        cnt_q[sel] <= '0;
      end else begin
        sum_q[sel] <= sum_new;
        cnt_q[sel] <= cnt_q[sel] + CNT_W'(1);
      end
      press_q[sel] <= press_next;
      if (calib) begin
        calib_q[sel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && calib) begin
      thr_q[sel] <= thr_new;
    end
  end

endmodule

@@ rtl/hall_key_hysteresis_detector.sv @@
// Top level of the Hall key detector: sample scaling pipeline and result register.
//
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   sensor_index_i, adc_raw_i, adc_error_i
// out      source     out_valid_o / out_stall_i result_sensor_o ... calibrated_now_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item is accepted per cycle while the pipeline is not held by out_stall_i.
// Stages: input register, clamp and multiply, divide by full scale, per-sensor
// read-modify-write of the window state into the result register.
// The whole pipeline holds while a result waits under out_stall_i.
// Reset clears all window, press and calibration flags at once; cfg is always ready.
`timescale 1ns / 1ps

module hall_key_hysteresis_detector
  import hkhd_pkg::*;
#(
  parameter int SENSORS  = SENSORS_DEF,
  parameter int SAMPLES  = SAMPLES_DEF,
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [IDX_W-1:0]     sensor_index_i,
  input  logic signed [RAW_W-1:0] adc_raw_i,
  input  logic                 adc_error_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     result_sensor_o,
  output logic                 window_done_o,
  output logic [MV_W-1:0]      average_mv_o,
  output logic                 key_pressed_o,
  output logic [1:0]           key_event_o,
  output logic                 calibrated_now_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int PW = ADC_BITS + 12;
  localparam logic signed [17:0] FULL_S = 18'((1 << ADC_BITS) - 1);
  localparam logic signed [17:0] HALF_S = 18'(1 << (ADC_BITS - 1));
  localparam logic [PW:0] FULL_U = (PW + 1)'((1 << ADC_BITS) - 1);

  cfg_t cfg_q;

  logic adv;

  logic                   s1_valid_q;
  logic [IDX_W-1:0]       s1_idx_q;
  logic signed [RAW_W-1:0] s1_raw_q;
  logic                   s1_err_q;

  logic                   s2_valid_q;
  logic [IDX_W-1:0]       s2_idx_q;
  logic [PW-1:0]          s2_prod_q;
  logic                   s2_err_q;

  logic                   s3_valid_q;
  logic [IDX_W-1:0]       s3_idx_q;
  logic [MV_W-1:0]        s3_mv_q;
  logic                   s3_err_q;

  logic                   out_valid_q;
  logic [IDX_W-1:0]       out_idx_q;
  bank_res_t              out_res_q;

  logic signed [17:0]     raw_x;
  logic signed [17:0]     raw_off;
  logic [ADC_BITS-1:0]    val;
  logic [PW-1:0]          prod_d;
  logic [PW:0]            q_sum;
  logic [PW:0]            q_est;
  logic [PW:0]            rem;
  logic [MV_W-1:0]        mv_d;
  bank_res_t              bank_res;

  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // clamp the offset sample to the converter range and scale by full-scale mV
  always_comb begin
    raw_x   = 18'(s1_raw_q);
    raw_off = (raw_x < 0) ? raw_x + HALF_S : raw_x;
    if (raw_off < 0) begin
      raw_off = '0;
    end else if (raw_off > FULL_S) begin
      raw_off = FULL_S;
    end
    val    = raw_off[ADC_BITS-1:0];
    prod_d = PW'(val) * PW'(MV_FULL);
  end

  // divide by 2^ADC_BITS - 1: shift-add estimate plus one correction step
  always_comb begin
    q_sum = {1'b0, s2_prod_q} + (PW + 1)'(s2_prod_q >> ADC_BITS);
    q_est = q_sum >> ADC_BITS;
    rem   = {1'b0, s2_prod_q} - (q_est << ADC_BITS) + q_est;
    mv_d  = q_est[MV_W-1:0] + MV_W'(rem >= FULL_U);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hysteresis_mv        <= HYST_RST;
      cfg_q.calibrate_enable     <= CAL_EN_RST;
      cfg_q.active_swing_mv      <= SWING_RST;
      cfg_q.default_threshold_mv <= DFLT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HYSTERESIS: cfg_q.hysteresis_mv        <= cfg_data_i;
        CFG_CAL_ENABLE: cfg_q.calibrate_enable     <= cfg_data_i[0];
        CFG_SWING:      cfg_q.active_swing_mv      <= cfg_data_i;
        CFG_DEFAULT:    cfg_q.default_threshold_mv <= cfg_data_i;
        default:        cfg_q                      <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_idx_q  <= sensor_index_i;
      s1_raw_q  <= adc_raw_i;
      s1_err_q  <= adc_error_i;
      s2_idx_q  <= s1_idx_q;
      s2_prod_q <= prod_d;
      s2_err_q  <= s1_err_q;
      s3_idx_q  <= s2_idx_q;
      s3_mv_q   <= mv_d;
      s3_err_q  <= s2_err_q;
      out_idx_q <= s3_idx_q;
      out_res_q <= bank_res;
    end
  end

  hkhd_sensor_bank #(
    .SENSORS (SENSORS),
    .SAMPLES (SAMPLES)
  ) u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s3_valid_q && adv),
    .sensor_i (s3_idx_q),
    .err_i    (s3_err_q),
    .mv_i     (s3_mv_q),
    .cfg_i    (cfg_q),
    .res_o    (bank_res)
  );

  assign out_valid_o      = out_valid_q;
  assign result_sensor_o  = out_idx_q;
  assign window_done_o    = out_res_q.window_done;
  assign average_mv_o     = out_res_q.average_mv;
  assign key_pressed_o    = out_res_q.key_pressed;
  assign key_event_o      = out_res_q.key_event;
  assign calibrated_now_o = out_res_q.calibrated_now;

  a_stall_only_on_out_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_event_matches_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_event_o != EV_NONE) |->
      (window_done_o && (key_pressed_o == (key_event_o == EV_PRESS))))
    else $error("key event disagrees with press state");

  a_calib_no_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && calibrated_now_o) |->
      (window_done_o && key_event_o == EV_NONE && average_mv_o != '0))
    else $error("calibration window carried an event");

  a_avg_only_when_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !window_done_o) |-> (average_mv_o == '0 && !calibrated_now_o))
    else $error("average reported without a finished window");

endmodule

@@ dv/tb_hall_key_hysteresis_detector.sv @@
// Self-checking testbench of the Hall key hysteresis detector with a scoreboard class.
`timescale 1ns / 1ps

module tb_hall_key_hysteresis_detector;
  import hkhd_pkg::*;

  localparam int FULL_CODE = (1 << ADC_BITS_DEF) - 1;
  localparam int THR_CEIL  = (1 << THR_W) - 1;

  typedef struct packed {
    logic [IDX_W-1:0] sensor;
    logic             done;
    logic [MV_W-1:0]  avg;
    logic             pressed;
    key_event_e       ev;
    logic             cal;
  } key_report_t;

  class key_scoreboard;
    logic [THR_W-1:0] hyst_mv;
    logic             cal_en;
    logic [THR_W-1:0] swing_mv;
    logic [THR_W-1:0] dflt_thr_mv;
    int unsigned      sum_mv[SENSORS_DEF];
    int unsigned      count[SENSORS_DEF];
    bit               pressed[SENSORS_DEF];
    int unsigned      thr_mv[SENSORS_DEF];
    bit               calibrated[SENSORS_DEF];
    key_report_t      expected_reports[$];
    int               fails;

    function new();
      hyst_mv     = HYST_RST;
      cal_en      = CAL_EN_RST;
      swing_mv    = SWING_RST;
      dflt_thr_mv = DFLT_RST;
      fails       = 0;
      for (int i = 0; i < SENSORS_DEF; i++) begin
        sum_mv[i]     = 0;
        count[i]      = 0;
        pressed[i]    = 1'b0;
        thr_mv[i]     = DFLT_RST;
        calibrated[i] = 1'b0;
      end
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_HYSTERESIS: hyst_mv = data;
        CFG_CAL_ENABLE: cal_en = data[0];
        CFG_SWING: swing_mv = data;
        CFG_DEFAULT: dflt_thr_mv = data;
        default: ;
      endcase
    endfunction

    function int threshold_of(int s);
      return calibrated[s] ? int'(thr_mv[s]) : int'(dflt_thr_mv);
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function int sample_mv(logic signed [RAW_W-1:0] raw);
      int v;
      v = raw;
      if (v < 0) v += 1 << (ADC_BITS_DEF - 1);
      if (v < 0) v = 0;
      if (v > FULL_CODE) v = FULL_CODE;
      return (v * MV_FULL) / FULL_CODE;
    endfunction

    function void note_sample(logic [IDX_W-1:0] s, logic signed [RAW_W-1:0] raw, logic err);
      key_report_t r;
      int avg;
      int thr;
      r = '0;
      r.sensor = s;
      r.ev = EV_NONE;
      if (err) begin
        sum_mv[s] = 0;
        count[s]  = 0;
      end else begin
        sum_mv[s] += sample_mv(raw);
        count[s]  += 1;
        if (count[s] >= SAMPLES_DEF) begin
          avg = sum_mv[s] / SAMPLES_DEF;
          r.done = 1'b1;
          r.avg = avg[MV_W-1:0];
          sum_mv[s] = 0;
          count[s]  = 0;
          if (cal_en && !calibrated[s] && avg > 0) begin
            thr = avg + (swing_mv >> 1);
            if (thr > THR_CEIL) thr = THR_CEIL;
            thr_mv[s] = thr;
            calibrated[s] = 1'b1;
            r.cal = 1'b1;
          end else begin
            thr = threshold_of(s);
            if (!pressed[s]) begin
              if (avg >= thr) begin
                pressed[s] = 1'b1;
                r.ev = EV_PRESS;
              end
            end else if (avg <= thr - int'(hyst_mv)) begin
              pressed[s] = 1'b0;
              r.ev = EV_RELEASE;
            end
          end
        end
      end
      r.pressed = pressed[s];
      expected_reports.push_back(r);
    endfunction

    function void check_report(key_report_t got);
      key_report_t want;
      if (expected_reports.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected report: sensor=%0d done=%0d avg=%0d pressed=%0d ev=%0d cal=%0d",
                   got.sensor, got.done, got.avg, got.pressed, got.ev, got.cal);
        return;
      end
      want = expected_reports.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10)
          $display("mismatch exp: sensor=%0d done=%0d avg=%0d pressed=%0d ev=%0d cal=%0d | act: sensor=%0d done=%0d avg=%0d pressed=%0d ev=%0d cal=%0d",
                   want.sensor, want.done, want.avg, want.pressed, want.ev, want.cal,
                   got.sensor, got.done, got.avg, got.pressed, got.ev, got.cal);
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [IDX_W-1:0]            sensor_index_i;
  logic signed [RAW_W-1:0]     adc_raw_i;
  logic                        adc_error_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [IDX_W-1:0]            result_sensor_o;
  logic                        window_done_o;
  logic [MV_W-1:0]             average_mv_o;
  logic                        key_pressed_o;
  logic [1:0]                  key_event_o;
  logic                        calibrated_now_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [CFG_DAT_W-1:0]        cfg_data_i;

  key_scoreboard sb = new();
  int  src_calm;
  int  sink_calm;
  bit  long_hold_req;
  int  level_mv[SENSORS_DEF];

  hall_key_hysteresis_detector uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sensor_index_i   (sensor_index_i),
    .adc_raw_i        (adc_raw_i),
    .adc_error_i      (adc_error_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_sensor_o  (result_sensor_o),
    .window_done_o    (window_done_o),
    .average_mv_o     (average_mv_o),
    .key_pressed_o    (key_pressed_o),
    .key_event_o      (key_event_o),
    .calibrated_now_o (calibrated_now_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic logic signed [RAW_W-1:0] mv_to_raw(int mv);
    int r;
    if (mv < 0) mv = 0;
    if (mv > MV_FULL) mv = MV_FULL;
    r = (mv * FULL_CODE + MV_FULL - 1) / MV_FULL;
    if (r < (1 << (ADC_BITS_DEF - 1)) && $urandom_range(0, 1) == 1)
      r -= 1 << (ADC_BITS_DEF - 1);
    return RAW_W'(r);
  endfunction

  function automatic int pick_level(int s);
    int t;
    t = sb.threshold_of(s);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return MV_FULL;
      2, 3: return t + $urandom_range(0, 80) - 40;
      4: return t - int'(sb.hyst_mv) - $urandom_range(0, 40);
      default: return $urandom_range(0, MV_FULL);
    endcase
  endfunction

  always @(posedge clk_i) begin
    key_report_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.sensor  = result_sensor_o;
      got.done    = window_done_o;
      got.avg     = average_mv_o;
      got.pressed = key_pressed_o;
      got.ev      = key_event_e'(key_event_o);
      got.cal     = calibrated_now_o;
      sb.check_report(got);
    end
  end

  initial begin
    int w;
    out_stall_i <= 1'b0;
    sink_calm = 0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        w = 400;
        long_hold_req = 1'b0;
      end else begin
        w = pick_wait(sink_calm);
      end
      if (w > 0) begin
        out_stall_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (w) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_sample(input logic [IDX_W-1:0] s, input logic signed [RAW_W-1:0] raw,
                             input logic err);
    int gap;
    gap = pick_wait(src_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sensor_index_i <= s;
    adc_raw_i      <= raw;
    adc_error_i    <= err;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s, raw, err);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_random(input int n, input int lo, input int hi);
    int s;
    logic signed [RAW_W-1:0] raw;
    logic err;
    s = lo;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) s = $urandom_range(lo, hi);
      if ($urandom_range(0, 11) == 0) level_mv[s] = pick_level(s);
      err = ($urandom_range(0, 29) == 0);
      if ($urandom_range(0, 19) == 0)
        raw = RAW_W'($urandom_range(0, (1 << RAW_W) - 1));
      else
        raw = mv_to_raw(level_mv[s] + $urandom_range(0, 60) - 30);
      send_sample(IDX_W'(s), raw, err);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    in_valid_i     <= 1'b0;
    sensor_index_i <= '0;
    adc_raw_i      <= '0;
    adc_error_i    <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_HYSTERESIS;
    cfg_data_i     <= '0;
    src_calm = 0;
    long_hold_req = 1'b0;
    foreach (level_mv[i]) level_mv[i] = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero average presses against the zero default threshold
    repeat (8) send_sample(4'd0, -13'sd2048, 1'b0);
    // converter error mid window, then a full-scale window calibrates with swing
    repeat (3) send_sample(4'd15, 13'sd4095, 1'b0);
    send_sample(4'd15, 13'sd4095, 1'b1);
    repeat (8) send_sample(4'd15, 13'sd4095, 1'b0);
    // offset and clamp of negative readings
    send_sample(4'd5, -13'sd1, 1'b0);
    send_sample(4'd5, -13'sd4096, 1'b0);
    send_sample(4'd5, 13'sd2048, 1'b0);
    send_sample(4'd5, 13'sd1, 1'b0);
    in_valid_i <= 1'b0;

    run_random(300, 0, 7);
    drain();

    write_cfg(CFG_HYSTERESIS, 12'd0);
    write_cfg(CFG_CAL_ENABLE, 12'd0);
    write_cfg(CFG_DEFAULT, 12'd1200);
    cfg_valid_i <= 1'b0;
    long_hold_req = 1'b1;
    run_random(300, 0, 15);
    drain();

    write_cfg(CFG_CAL_ENABLE, 12'd1);
    write_cfg(CFG_SWING, 12'd4095);
    write_cfg(CFG_HYSTERESIS, 12'd3300);
    cfg_valid_i <= 1'b0;
    run_random(300, 8, 15);
    drain();

    write_cfg(CFG_CAL_ENABLE, 12'd0);
    write_cfg(CFG_SWING, 12'd0);
    write_cfg(CFG_DEFAULT, 12'd4095);
    write_cfg(CFG_HYSTERESIS, 12'd4095);
    cfg_valid_i <= 1'b0;
    run_random(300, 0, 15);
    drain();

    write_cfg(CFG_HYSTERESIS, CFG_DAT_W'($urandom_range(0, 4095)));
    write_cfg(CFG_CAL_ENABLE, CFG_DAT_W'($urandom_range(0, 1)));
    write_cfg(CFG_SWING, CFG_DAT_W'($urandom_range(0, 4095)));
    write_cfg(CFG_DEFAULT, CFG_DAT_W'($urandom_range(0, 4095)));
    cfg_valid_i <= 1'b0;
    long_hold_req = 1'b1;
    run_random(300, 0, 15);
    drain();

    write_cfg(CFG_HYSTERESIS, HYST_RST);
    write_cfg(CFG_CAL_ENABLE, 12'd1);
    write_cfg(CFG_SWING, SWING_RST);
    write_cfg(CFG_DEFAULT, CFG_DAT_W'($urandom_range(0, 3300)));
    cfg_valid_i <= 1'b0;
    run_random(276, 0, 15);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
